@@ rtl/char_lcd_bus_sequencer_defines.svh @@
// assertion macros for the character-lcd bus sequencer checker
// no dependencies; the including module must provide i_clk and i_rst_n
`ifndef CHAR_LCD_BUS_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_BUS_SEQUENCER_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define LCDSEQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lcdseq check failed");

// next-cycle implication, sampled on i_clk, off during reset
`define LCDSEQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lcdseq check failed");

`endif

@@ rtl/lcdseq_pkg.sv @@
// shared types, constants and microcode rom of the lcd bus sequencer
// no dependencies
package lcdseq_pkg;

    localparam int PC_W   = 6;
    localparam int HOLD_W = 15;

    typedef logic [PC_W-1:0] t_pc;

    // command codes
    typedef enum logic [1:0] {
        CMD_INIT  = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_HOME  = 2'd2,
        CMD_WRITE = 2'd3
    } t_cmd;

    // register indexes on the apb port
    typedef enum logic [1:0] {
        REG_FUNCTION = 2'd0,
        REG_DISPLAY  = 2'd1,
        REG_ENTRY    = 2'd2
    } t_reg;

    // byte sources for the data lines
    typedef enum logic [2:0] {
        SRC_ZERO  = 3'd0,
        SRC_FUNC  = 3'd1,
        SRC_DISP  = 3'd2,
        SRC_ENTRY = 3'd3,
        SRC_CLEAR = 3'd4,
        SRC_HOME  = 3'd5,
        SRC_ADDR  = 3'd6,
        SRC_CHAR  = 3'd7
    } t_src;

    // hold time selects
    typedef enum logic [1:0] {
        HOLD_STROBE  = 2'd0,
        HOLD_SHORT   = 2'd1,
        HOLD_LONG    = 2'd2,
        HOLD_POWERUP = 2'd3
    } t_hold;

    localparam logic [7:0] CLEAR_CODE = 8'h01;
    localparam logic [7:0] HOME_CODE  = 8'h02;

    localparam logic [7:0] FUNCTION_RST = 8'h28;
    localparam logic [7:0] DISPLAY_RST  = 8'h0F;
    localparam logic [7:0] ENTRY_RST    = 8'h07;

    localparam logic [HOLD_W-1:0] STROBE_US  = 15'd30;
    localparam logic [HOLD_W-1:0] SHORT_US   = 15'd67;    // 30 + 37
    localparam logic [HOLD_W-1:0] LONG_US    = 15'd2030;  // 30 + 2000
    localparam logic [HOLD_W-1:0] POWERUP_US = 15'd20000;

    // program entry points
    localparam t_pc PC_INIT  = 6'd0;
    localparam t_pc PC_CLEAR = 6'd21;
    localparam t_pc PC_HOME  = 6'd26;
    localparam t_pc PC_WRITE = 6'd31;

    typedef struct packed {
        logic [7:0] function_word;
        logic [7:0] display_word;
        logic [7:0] entry_word;
    } t_cfg;

    typedef struct packed {
        t_src  src;
        logic  nib;       // low nibble moved to the upper lines
        logic  rs;
        logic  en;
        t_hold hold;
        logic  jmp_wide;  // branch to target in eight-bit mode
        t_pc   target;
        logic  last;
    } t_uword;

    typedef struct packed {
        logic   fire;     // load this word into the output register
        t_uword word;
    } t_step;

    function automatic t_uword uw(t_src src, logic nib, logic rs, logic en,
                                  t_hold hold, logic jmp, t_pc tgt, logic last);
        t_uword w;
        w.src      = src;
        w.nib      = nib;
        w.rs       = rs;
        w.en       = en;
        w.hold     = hold;
        w.jmp_wide = jmp;
        w.target   = tgt;
        w.last     = last;
        return w;
    endfunction

    function automatic t_pc entry_pc(t_cmd cmd);
        t_pc pc;
        case (cmd)
            CMD_INIT:  pc = PC_INIT;
            CMD_CLEAR: pc = PC_CLEAR;
            CMD_HOME:  pc = PC_HOME;
            CMD_WRITE: pc = PC_WRITE;
            default:   pc = PC_INIT;
        endcase
        return pc;
    endfunction

    // each byte transfer: strobe high, strobe low (skip nibble pair in
    // eight-bit mode), nibble high, nibble low, closing wait
    function automatic t_uword ucode_rom(t_pc pc);
        t_uword w;
        case (pc)
            // initialise
            6'd0:  w = uw(SRC_ZERO,  1'b0, 1'b0, 1'b0, HOLD_POWERUP, 1'b0, 6'd0,  1'b0);
            6'd1:  w = uw(SRC_FUNC,  1'b0, 1'b0, 1'b1, HOLD_STROBE,  1'b0, 6'd0,  1'b0);
            6'd2:  w = uw(SRC_FUNC,  1'b0, 1'b0, 1'b0, HOLD_STROBE,  1'b1, 6'd5,  1'b0);
            6'd3:  w = uw(SRC_FUNC,  1'b1, 1'b0, 1'b1, HOLD_STROBE,  1'b0, 6'd0,  1'b0);
            6'd4:  w = uw(SRC_FUNC,  1'b1, 1'b0, 1'b0, HOLD_STROBE,  1'b0, 6'd0,  1'b0);
            6'd5:  w = uw(SRC_ZERO,  1'b0, 1'b0, 1'b0, HOLD_SHORT,   1'b0, 6'd0,  1'b0);
            6'd6:  w = uw(SRC_DISP,  1'b0, 1'b0, 1'b1, HOLD_STROBE,  1'b0, 6'd0,  1'b0);
            6'd7:  w = uw(SRC_DISP,  1'b0, 1'b0, 1'b0, HOLD_STROBE,  1'b1, 6'd10, 1'b0);
            6'd8:  w = uw(SRC_DISP,  1'b1, 1'b0, 1'b1, HOLD_STROBE,  1'b0, 6'd0,  1'b0);
            6'd9:  w = uw(SRC_DISP,  1'b1, 1'b0, 1'b0, HOLD_STROBE,  1'b0, 6'd0,  1'b0);
            6'd10: w = uw(SRC_ZERO,  1'b0, 1'b0, 1'b0, HOLD_SHORT,   1'b0, 6'd0,  1'b0);
            6'd11: w = uw(SRC_CLEAR, 1'b0, 1'b0, 1'b1, HOLD_STROBE,  1'b0, 6'd0,  1'b0);
            6'd12: w = uw(SRC_CLEAR, 1'b0, 1'b0, 1'b0, HOLD_STROBE,  1'b1, 6'd15, 1'b0);
            6'd13: w = uw(SRC_CLEAR, 1'b1, 1'b0, 1'b1, HOLD_STROBE,  1'b0, 6'd0,  1'b0);
            6'd14: w = uw(SRC_CLEAR, 1'b1, 1'b0, 1'b0, HOLD_STROBE,  1'b0, 6'd0,  1'b0);
            6'd15: w = uw(SRC_ZERO,  1'b0, 1'b0, 1'b0, HOLD_LONG,    1'b0, 6'd0,  1'b0);
            6'd16: w = uw(SRC_ENTRY, 1'b0, 1'b0, 1'b1, HOLD_STROBE,  1'b0, 6'd0,  1'b0);
            6'd17: w = uw(SRC_ENTRY, 1'b0, 1'b0, 1'b0, HOLD_STROBE,  1'b1, 6'd20, 1'b0);
            6'd18: w = uw(SRC_ENTRY, 1'b1, 1'b0, 1'b1, HOLD_STROBE,  1'b0, 6'd0,  1'b0);
            6'd19: w = uw(SRC_ENTRY, 1'b1, 1'b0, 1'b0, HOLD_STROBE,  1'b0, 6'd0,  1'b0);
            6'd20: w = uw(SRC_ZERO,  1'b0, 1'b0, 1'b0, HOLD_SHORT,   1'b0, 6'd0,  1'b1);
            // clear display
            6'd21: w = uw(SRC_CLEAR, 1'b0, 1'b0, 1'b1, HOLD_STROBE,  1'b0, 6'd0,  1'b0);
            6'd22: w = uw(SRC_CLEAR, 1'b0, 1'b0, 1'b0, HOLD_STROBE,  1'b1, 6'd25, 1'b0);
            6'd23: w = uw(SRC_CLEAR, 1'b1, 1'b0, 1'b1, HOLD_STROBE,  1'b0, 6'd0,  1'b0);
            6'd24: w = uw(SRC_CLEAR, 1'b1, 1'b0, 1'b0, HOLD_STROBE,  1'b0, 6'd0,  1'b0);
            6'd25: w = uw(SRC_ZERO,  1'b0, 1'b0, 1'b0, HOLD_LONG,    1'b0, 6'd0,  1'b1);
            // return home
            6'd26: w = uw(SRC_HOME,  1'b0, 1'b0, 1'b1, HOLD_STROBE,  1'b0, 6'd0,  1'b0);
            6'd27: w = uw(SRC_HOME,  1'b0, 1'b0, 1'b0, HOLD_STROBE,  1'b1, 6'd30, 1'b0);
            6'd28: w = uw(SRC_HOME,  1'b1, 1'b0, 1'b1, HOLD_STROBE,  1'b0, 6'd0,  1'b0);
            6'd29: w = uw(SRC_HOME,  1'b1, 1'b0, 1'b0, HOLD_STROBE,  1'b0, 6'd0,  1'b0);
            6'd30: w = uw(SRC_ZERO,  1'b0, 1'b0, 1'b0, HOLD_LONG,    1'b0, 6'd0,  1'b1);
            // write character: address instruction, then data
            6'd31: w = uw(SRC_ADDR,  1'b0, 1'b0, 1'b1, HOLD_STROBE,  1'b0, 6'd0,  1'b0);
            6'd32: w = uw(SRC_ADDR,  1'b0, 1'b0, 1'b0, HOLD_STROBE,  1'b1, 6'd35, 1'b0);
            6'd33: w = uw(SRC_ADDR,  1'b1, 1'b0, 1'b1, HOLD_STROBE,  1'b0, 6'd0,  1'b0);
            6'd34: w = uw(SRC_ADDR,  1'b1, 1'b0, 1'b0, HOLD_STROBE,  1'b0, 6'd0,  1'b0);
            6'd35: w = uw(SRC_ZERO,  1'b0, 1'b0, 1'b0, HOLD_SHORT,   1'b0, 6'd0,  1'b0);
            6'd36: w = uw(SRC_CHAR,  1'b0, 1'b1, 1'b1, HOLD_STROBE,  1'b0, 6'd0,  1'b0);
            6'd37: w = uw(SRC_CHAR,  1'b0, 1'b1, 1'b0, HOLD_STROBE,  1'b1, 6'd40, 1'b0);
            6'd38: w = uw(SRC_CHAR,  1'b1, 1'b1, 1'b1, HOLD_STROBE,  1'b0, 6'd0,  1'b0);
            6'd39: w = uw(SRC_CHAR,  1'b1, 1'b1, 1'b0, HOLD_STROBE,  1'b0, 6'd0,  1'b0);
            6'd40: w = uw(SRC_ZERO,  1'b0, 1'b1, 1'b0, HOLD_SHORT,   1'b0, 6'd0,  1'b1);
            default: w = uw(SRC_ZERO, 1'b0, 1'b0, 1'b0, HOLD_STROBE, 1'b0, 6'd0,  1'b1);
        endcase
        return w;
    endfunction

endpackage

@@ rtl/char_lcd_bus_sequencer.sv @@
// top level of the character-lcd bus sequencer
// depends on lcdseq_pkg, lcdseq_cfg, lcdseq_ucode, lcdseq_dpath
//
//  channel   direction  handshake                   payload
//  command   in         i_in_valid / o_in_stall     i_command, i_character, i_position
//  phase     out        o_out_valid / i_out_stall   o_data_bus, o_reg_select, o_read_write,
//                                                   o_enable, o_hold_us, o_last
//  config    in         apb psel/penable/pready     paddr, pwdata, prdata
//
// an accepted command runs from the microcode rom, one bus phase per cycle
// while the output register is not stalled: 21 phases for initialise in
// four-bit mode (13 in eight-bit), 5 (3) for clear or home, 10 (6) for a character write
// the next command is taken the cycle after the last phase enters the output
// register; a stalled output register freezes the step counter
// synchronous active-low reset clears the sequencer and loads register defaults
module char_lcd_bus_sequencer (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // command channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_command,
    input  logic [7:0]                i_character,
    input  logic [6:0]                i_position,
    // phase channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [7:0]                o_data_bus,
    output logic                      o_reg_select,
    output logic                      o_read_write,
    output logic                      o_enable,
    output logic [lcdseq_pkg::HOLD_W-1:0] o_hold_us,
    output logic                      o_last,
    // register port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [3:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import lcdseq_pkg::*;

    t_cfg  w_cfg;
    t_step w_step;
    logic  w_busy;
    logic  w_adv;
    logic  w_accept;

    // one command in flight; busy until its last phase is loaded
    assign o_in_stall = w_busy;
    assign w_accept   = i_in_valid && !w_busy;

    lcdseq_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // bit 4 of the function word set means eight-bit transfers: the
    // sequencer branches over the nibble pair of every byte
    lcdseq_ucode u_ucode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_cmd       (t_cmd'(i_command)),
        .i_eight_bit (w_cfg.function_word[4]),
        .i_adv       (w_adv),
        .o_busy      (w_busy),
        .o_step      (w_step)
    );

    // datapath picks the byte and hold time and holds the phase for transfer
    lcdseq_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_character  (i_character),
        .i_position   (i_position),
        .i_cfg        (w_cfg),
        .i_step       (w_step),
        .i_out_stall  (i_out_stall),
        .o_adv        (w_adv),
        .o_out_valid  (o_out_valid),
        .o_data_bus   (o_data_bus),
        .o_reg_select (o_reg_select),
        .o_read_write (o_read_write),
        .o_enable     (o_enable),
        .o_hold_us    (o_hold_us),
        .o_last       (o_last)
    );

endmodule

@@ rtl/lcdseq_cfg.sv @@
// apb register block: function, display and entry-mode words
// depends on lcdseq_pkg
module lcdseq_cfg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output lcdseq_pkg::t_cfg   o_cfg
);
    import lcdseq_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;
    t_reg w_idx;
    logic w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                REG_FUNCTION: n_cfg.function_word = pwdata[7:0];
                REG_DISPLAY:  n_cfg.display_word  = pwdata[7:0];
                REG_ENTRY:    n_cfg.entry_word    = pwdata[7:0];
                default:      n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.function_word <= FUNCTION_RST;
            r_cfg.display_word  <= DISPLAY_RST;
            r_cfg.entry_word    <= ENTRY_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (w_idx)
            REG_FUNCTION: prdata = {24'd0, r_cfg.function_word};
            REG_DISPLAY:  prdata = {24'd0, r_cfg.display_word};
            REG_ENTRY:    prdata = {24'd0, r_cfg.entry_word};
            default:      prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/lcdseq_ucode.sv @@
// microcode sequencer: step counter, busy flag, rom fetch and branch
// depends on lcdseq_pkg
module lcdseq_ucode (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  lcdseq_pkg::t_cmd    i_cmd,
    input  logic                i_eight_bit,
    input  logic                i_adv,
    output logic                o_busy,
    output lcdseq_pkg::t_step   o_step
);
    import lcdseq_pkg::*;

    logic   r_busy;
    logic   n_busy;
    t_pc    r_pc;
    t_pc    n_pc;
    t_uword w_word;
    logic   w_fire;

    assign w_word = ucode_rom(r_pc);
    assign w_fire = r_busy && i_adv;

    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        if (i_accept) begin
            n_busy = 1'b1;
            n_pc   = entry_pc(i_cmd);
        end else if (w_fire) begin
            n_busy = !w_word.last;
            n_pc   = (w_word.jmp_wide && i_eight_bit) ? w_word.target : r_pc + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= PC_INIT;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
        end
    end

    assign o_busy      = r_busy;
    assign o_step.fire = w_fire;
    assign o_step.word = w_word;

endmodule

@@ rtl/lcdseq_dpath.sv @@
// datapath: operand latch, byte and hold selection, output register
// depends on lcdseq_pkg
module lcdseq_dpath (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  logic [7:0]               i_character,
    input  logic [6:0]               i_position,
    input  lcdseq_pkg::t_cfg         i_cfg,
    input  lcdseq_pkg::t_step        i_step,
    input  logic                     i_out_stall,
    output logic                     o_adv,
    output logic                     o_out_valid,
    output logic [7:0]               o_data_bus,
    output logic                     o_reg_select,
    output logic                     o_read_write,
    output logic                     o_enable,
    output logic [lcdseq_pkg::HOLD_W-1:0] o_hold_us,
    output logic                     o_last
);
    import lcdseq_pkg::*;

    logic [7:0]        r_char;
    logic [6:0]        r_pos;
    logic              r_valid;
    logic              n_valid;
    logic [7:0]        r_data;
    logic              r_rs;
    logic              r_en;
    logic [HOLD_W-1:0] r_hold;
    logic              r_last;
    logic [7:0]        w_byte;
    logic [7:0]        w_lanes;
    logic [HOLD_W-1:0] w_hold;

    always_comb begin
        case (i_step.word.src)
            SRC_ZERO:  w_byte = 8'd0;
            SRC_FUNC:  w_byte = i_cfg.function_word;
            SRC_DISP:  w_byte = i_cfg.display_word;
            SRC_ENTRY: w_byte = i_cfg.entry_word;
            SRC_CLEAR: w_byte = CLEAR_CODE;
            SRC_HOME:  w_byte = HOME_CODE;
            SRC_ADDR:  w_byte = {1'b1, r_pos};
            SRC_CHAR:  w_byte = r_char;
            default:   w_byte = 8'd0;
        endcase
    end

    assign w_lanes = i_step.word.nib ? {w_byte[3:0], 4'd0} : w_byte;

    always_comb begin
        case (i_step.word.hold)
            HOLD_STROBE:  w_hold = STROBE_US;
            HOLD_SHORT:   w_hold = SHORT_US;
            HOLD_LONG:    w_hold = LONG_US;
            HOLD_POWERUP: w_hold = POWERUP_US;
            default:      w_hold = STROBE_US;
        endcase
    end

    assign o_adv   = !r_valid || !i_out_stall;
    assign n_valid = i_step.fire ? 1'b1 : (r_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_char <= i_character;
            r_pos  <= i_position;
        end
        if (i_step.fire) begin
            r_data <= w_lanes;
            r_rs   <= i_step.word.rs;
            r_en   <= i_step.word.en;
            r_hold <= w_hold;
            r_last <= i_step.word.last;
        end
    end

    assign o_out_valid  = r_valid;
    assign o_data_bus   = r_data;
    assign o_reg_select = r_rs;
    assign o_read_write = 1'b0;
    assign o_enable     = r_en;
    assign o_hold_us    = r_hold;
    assign o_last       = r_last;

endmodule

@@ rtl/lcdseq_checker.sv @@
// port-level checks for the character-lcd bus sequencer, bound to the top
// depends on char_lcd_bus_sequencer_defines.svh
`include "char_lcd_bus_sequencer_defines.svh"

module lcdseq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [7:0]  o_data_bus,
    input logic        o_read_write,
    input logic        o_enable,
    input logic [14:0] o_hold_us,
    input logic        o_last
);

    // a stalled phase holds
    `LCDSEQ_ASSERT_NXT(a_stall_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_data_bus) && $stable(o_hold_us) && $stable(o_last))

    // an accepted command blocks the next one
    `LCDSEQ_ASSERT_NXT(a_one_cmd, i_in_valid && !o_in_stall, o_in_stall)

    // a strobe-high transfer is followed at once by its strobe-low phase
    `LCDSEQ_ASSERT_NXT(a_strobe_pair, o_out_valid && !i_out_stall && o_enable, o_out_valid && !o_enable && o_data_bus == $past(o_data_bus))

    // closing phase releases the data lines and the strobe
    `LCDSEQ_ASSERT_IMP(a_last_idle, o_out_valid && o_last, o_data_bus == 8'd0 && !o_enable && !o_read_write)

endmodule

bind char_lcd_bus_sequencer lcdseq_checker u_lcdseq_checker (.*);

@@ dv/char_lcd_bus_sequencer_checker.sv @@
// phase predictor and scoreboard for the character-lcd bus sequencer
// depends on lcdseq_pkg; watches the command, phase and register channels
module char_lcd_bus_sequencer_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [1:0]                    i_command,
    input  logic [7:0]                    i_character,
    input  logic [6:0]                    i_position,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [7:0]                    i_data_bus,
    input  logic                          i_reg_select,
    input  logic                          i_read_write,
    input  logic                          i_enable,
    input  logic [lcdseq_pkg::HOLD_W-1:0] i_hold_us,
    input  logic                          i_last,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [3:0]                    i_paddr,
    input  logic [31:0]                   i_pwdata,
    input  logic [31:0]                   i_prdata,
    input  logic                          i_pready,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_phase_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import lcdseq_pkg::*;

    localparam logic [HOLD_W-1:0] STROBE_HOLD  = 15'd30;
    localparam logic [HOLD_W-1:0] SHORT_WAIT   = 15'd37;
    localparam logic [HOLD_W-1:0] LONG_WAIT    = 15'd2000;
    localparam logic [HOLD_W-1:0] POWERUP_HOLD = 15'd20000;
    localparam logic [7:0] CLEAR_INSTR   = 8'h01;
    localparam logic [7:0] HOME_INSTR    = 8'h02;
    localparam logic [7:0] SET_ADDR_FLAG = 8'h80;

    typedef struct packed {
        logic [7:0]        data;
        logic              rs;
        logic              rw;
        logic              en;
        logic [HOLD_W-1:0] hold;
        logic              last;
    } t_phase;

    t_phase     expected_phases[$];
    t_phase     got;
    t_phase     want;
    logic [7:0] function_word;
    logic [7:0] display_word;
    logic [7:0] entry_word;
    logic [7:0] reg_value;
    logic       reg_known;

    initial begin
        o_fail_count  = 0;
        o_pending     = 0;
        o_phase_count = 0;
    end

    function automatic void note_failure(string msg);
        o_fail_count++;
        if (o_fail_count <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    function automatic void add_phase(logic [7:0] data, logic rs, logic en,
                                      logic [HOLD_W-1:0] hold);
        t_phase p;
        p.data = data;
        p.rs   = rs;
        p.rw   = 1'b0;
        p.en   = en;
        p.hold = hold;
        p.last = 1'b0;
        expected_phases.push_back(p);
    endfunction

    // strobe pair, nibble pair in four-bit mode, then the closing wait
    function automatic void add_transfer(logic [7:0] value, logic rs,
                                         logic [HOLD_W-1:0] wait_us);
        add_phase(value, rs, 1'b1, STROBE_HOLD);
        add_phase(value, rs, 1'b0, STROBE_HOLD);
        if (!function_word[4]) begin
            add_phase({value[3:0], 4'h0}, rs, 1'b1, STROBE_HOLD);
            add_phase({value[3:0], 4'h0}, rs, 1'b0, STROBE_HOLD);
        end
        add_phase(8'h00, rs, 1'b0, STROBE_HOLD + wait_us);
    endfunction

    function automatic void predict_command(t_cmd cmd, logic [7:0] ch, logic [6:0] pos);
        t_phase tail;
        case (cmd)
            CMD_INIT: begin
                add_phase(8'h00, 1'b0, 1'b0, POWERUP_HOLD);
                add_transfer(function_word, 1'b0, SHORT_WAIT);
                add_transfer(display_word, 1'b0, SHORT_WAIT);
                add_transfer(CLEAR_INSTR, 1'b0, LONG_WAIT);
                add_transfer(entry_word, 1'b0, SHORT_WAIT);
            end
            CMD_CLEAR: add_transfer(CLEAR_INSTR, 1'b0, LONG_WAIT);
            CMD_HOME:  add_transfer(HOME_INSTR, 1'b0, LONG_WAIT);
            default: begin
                add_transfer(SET_ADDR_FLAG | {1'b0, pos}, 1'b0, SHORT_WAIT);
                add_transfer(ch, 1'b1, SHORT_WAIT);
            end
        endcase
        tail = expected_phases.pop_back();
        tail.last = 1'b1;
        expected_phases.push_back(tail);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            function_word = FUNCTION_RST;
            display_word  = DISPLAY_RST;
            entry_word    = ENTRY_RST;
            expected_phases.delete();
        end else begin
            reg_known = 1'b1;
            case (t_reg'(i_paddr[3:2]))
                REG_FUNCTION: reg_value = function_word;
                REG_DISPLAY:  reg_value = display_word;
                REG_ENTRY:    reg_value = entry_word;
                default:      reg_known = 1'b0;
            endcase
            if (i_psel && i_penable && i_pready && !i_pwrite && reg_known &&
                i_prdata !== {24'h0, reg_value})
                note_failure($sformatf("read of register %0d: expected %08h got %08h",
                                       i_paddr[3:2], {24'h0, reg_value}, i_prdata));
            // writes to an index past the register list are dropped
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg'(i_paddr[3:2]))
                    REG_FUNCTION: function_word = i_pwdata[7:0];
                    REG_DISPLAY:  display_word  = i_pwdata[7:0];
                    REG_ENTRY:    entry_word    = i_pwdata[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                predict_command(t_cmd'(i_command), i_character, i_position);
            if (i_out_valid && !i_out_stall) begin
                got.data = i_data_bus;
                got.rs   = i_reg_select;
                got.rw   = i_read_write;
                got.en   = i_enable;
                got.hold = i_hold_us;
                got.last = i_last;
                o_phase_count++;
                if (expected_phases.size() == 0) begin
                    note_failure($sformatf({"phase with none expected: data %02h rs %0b ",
                                            "rw %0b en %0b hold %0d last %0b"},
                                           got.data, got.rs, got.rw, got.en,
                                           got.hold, got.last));
                end else begin
                    want = expected_phases.pop_front();
                    if (got.data !== want.data || got.rs !== want.rs ||
                        got.rw !== want.rw || got.en !== want.en ||
                        got.hold !== want.hold || got.last !== want.last)
                        note_failure($sformatf({"expected data %02h rs %0b rw %0b en %0b ",
                                                "hold %0d last %0b, ",
                                                "got data %02h rs %0b rw %0b en %0b ",
                                                "hold %0d last %0b"},
                                               want.data, want.rs, want.rw, want.en,
                                               want.hold, want.last,
                                               got.data, got.rs, got.rw, got.en,
                                               got.hold, got.last));
                end
            end
        end
        o_pending = expected_phases.size();
    end

endmodule

@@ dv/char_lcd_bus_sequencer_tb.sv @@
// top of the character-lcd bus sequencer testbench: clock, reset, stimulus, verdict
// depends on lcdseq_pkg, char_lcd_bus_sequencer and char_lcd_bus_sequencer_checker
module char_lcd_bus_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lcdseq_pkg::*;

    localparam int          LIMIT_CYCLES  = 600000;
    localparam int          PHASE_ITEMS   = 64;    // random commands per register setting
    localparam int          SETTINGS_RUNS = 8;
    localparam logic [3:0]  SPARE_ADDR    = 4'd12; // first index past the register list

    // receiver stall patterns
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_COIN,
        STALL_MOSTLY,
        STALL_RUNS
    } t_stall_mode;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [1:0]        i_command;
    logic [7:0]        i_character;
    logic [6:0]        i_position;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [7:0]        o_data_bus;
    logic              o_reg_select;
    logic              o_read_write;
    logic              o_enable;
    logic [HOLD_W-1:0] o_hold_us;
    logic              o_last;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [3:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    int fail_count;
    int pending;
    int phase_count;
    int cmd_count[4];
    int setting_count;
    int read_count;
    int cycle_count;

    char_lcd_bus_sequencer u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_character  (i_character),
        .i_position   (i_position),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_data_bus   (o_data_bus),
        .o_reg_select (o_reg_select),
        .o_read_write (o_read_write),
        .o_enable     (o_enable),
        .o_hold_us    (o_hold_us),
        .o_last       (o_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // checker sits beside the block and only watches its ports
    char_lcd_bus_sequencer_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_character   (i_character),
        .i_position    (i_position),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_data_bus    (o_data_bus),
        .i_reg_select  (o_reg_select),
        .i_read_write  (o_read_write),
        .i_enable      (o_enable),
        .i_hold_us     (o_hold_us),
        .i_last        (o_last),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_prdata      (prdata),
        .i_pready      (pready),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_phase_count (phase_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog: the slowest legal run is far below this
    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d phases still expected", cycle_count, pending);
        $display("char_lcd_bus_sequencer_tb failed");
        $finish;
    end

    // receiver side: a random stall pattern for each stretch, among them
    // stretches of no stall at all so the block runs at full rate too
    initial begin
        t_stall_mode stall_mode;
        int          mode_left;
        int          run_left;
        logic        run_high;
        stall_mode  = STALL_NONE;
        mode_left   = 0;
        run_left    = 0;
        run_high    = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                mode_left  = $urandom_range(20, 120);
            end
            mode_left--;
            case (stall_mode)
                STALL_NONE:   i_out_stall <= 1'b0;
                STALL_COIN:   i_out_stall <= 1'($urandom_range(0, 1));
                STALL_MOSTLY: i_out_stall <= (mode_left % 4) != 0;
                default: begin
                    // alternating runs, long stalls against short openings
                    if (run_left == 0) begin
                        run_high = ~run_high;
                        run_left = run_high ? $urandom_range(1, 6) : $urandom_range(1, 3);
                    end
                    run_left--;
                    i_out_stall <= run_high;
                end
            endcase
        end
    end

    function automatic logic [3:0] reg_addr(t_reg r);
        return {r, 2'b00};
    endfunction

    // one apb transfer: setup cycle, access cycle, done when pready is seen
    task automatic apb_access(logic wr, logic [3:0] addr, logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (!wr)
            read_count++;
    endtask

    // present one command and hold it until the block takes the transfer;
    // valid stays high when the next call follows straight away
    task automatic push_command(t_cmd cmd, logic [7:0] ch, logic [6:0] pos);
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_command   <= cmd;
        i_character <= ch;
        i_position  <= pos;
        do @(posedge i_clk); while (o_in_stall);
        cmd_count[cmd]++;
    endtask

    // sender idle with valid low for the given gap; the payload wanders so a stuck block shows up
    task automatic sender_gap(int n);
        repeat (n) begin
            @(negedge i_clk);
            i_in_valid  <= 1'b0;
            i_command   <= 2'($urandom);
            i_character <= 8'($urandom);
            i_position  <= 7'($urandom);
        end
    endtask

    // drop valid and let every expected phase come out before touching registers
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_words(logic [31:0] func_w, logic [31:0] disp_w, logic [31:0] entry_w);
        apb_access(1'b1, reg_addr(REG_FUNCTION), func_w);
        apb_access(1'b1, reg_addr(REG_DISPLAY), disp_w);
        apb_access(1'b1, reg_addr(REG_ENTRY), entry_w);
        setting_count++;
    endtask

    // new random register setting, extremes of the byte now and then
    task automatic random_setting();
        t_reg        regs[3];
        logic [31:0] value;
        regs = '{REG_FUNCTION, REG_DISPLAY, REG_ENTRY};
        foreach (regs[k]) begin
            if ($urandom_range(0, 3) != 0) begin
                value = $urandom;
                case ($urandom_range(0, 5))
                    0: value[7:0] = 8'h00;
                    1: value[7:0] = 8'hFF;
                    default: ;
                endcase
                apb_access(1'b1, reg_addr(regs[k]), value);
            end
        end
        if ($urandom_range(0, 3) == 0)
            apb_access(1'b1, SPARE_ADDR, $urandom);
        apb_access(1'b0, reg_addr(regs[$urandom_range(0, 2)]), 32'h0);
        setting_count++;
    endtask

    initial begin
        int   sent;
        int   burst_len;
        t_cmd cmd;

        // every input known from time zero, reset held low before release
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_command   = CMD_INIT;
        i_character = 8'h00;
        i_position  = 7'h00;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = 4'h0;
        pwdata      = 32'h0;
        setting_count = 1;
        read_count    = 0;
        foreach (cmd_count[k])
            cmd_count[k] = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: four-bit mode, read back all three words
        apb_access(1'b0, reg_addr(REG_FUNCTION), 32'h0);
        apb_access(1'b0, reg_addr(REG_DISPLAY), 32'h0);
        apb_access(1'b0, reg_addr(REG_ENTRY), 32'h0);
        push_command(CMD_INIT, 8'h00, 7'h00);
        push_command(CMD_CLEAR, 8'h00, 7'h00);
        push_command(CMD_HOME, 8'h00, 7'h00);
        push_command(CMD_WRITE, 8'h00, 7'h00);
        push_command(CMD_WRITE, 8'hFF, 7'h7F);
        wait_drained();

        // eight-bit mode with junk in the upper data bits; a write past the
        // register list must leave the words alone
        set_words(32'hFFFF_FF38, 32'h0000_0000, 32'hA5A5_00FF);
        apb_access(1'b1, SPARE_ADDR, 32'hFFFF_FF10);
        apb_access(1'b0, reg_addr(REG_FUNCTION), 32'h0);
        push_command(CMD_INIT, 8'h00, 7'h00);
        push_command(CMD_CLEAR, 8'hFF, 7'h7F);
        push_command(CMD_HOME, 8'hFF, 7'h7F);
        push_command(CMD_WRITE, 8'h5A, 7'h55);
        push_command(CMD_WRITE, 8'hA5, 7'h2A);
        wait_drained();

        // all-zero function word (four-bit), opposite extremes elsewhere
        set_words(32'h0000_0000, 32'h0000_00FF, 32'h0000_0000);
        push_command(CMD_INIT, 8'h00, 7'h00);
        push_command(CMD_WRITE, 8'hFF, 7'h7F);
        wait_drained();

        // all-ones function word (eight-bit)
        set_words(32'h0000_00FF, 32'h0000_0080, 32'h0000_0001);
        push_command(CMD_INIT, 8'h00, 7'h00);
        push_command(CMD_WRITE, 8'h00, 7'h00);
        push_command(CMD_CLEAR, 8'h00, 7'h00);
        push_command(CMD_HOME, 8'h00, 7'h00);
        wait_drained();

        // random part: mostly character writes, bursts of commands with gaps
        repeat (SETTINGS_RUNS) begin
            random_setting();
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                burst_len = ($urandom_range(0, 7) == 0) ? 16 : $urandom_range(1, 6);
                for (int k = 0; k < burst_len && sent < PHASE_ITEMS; k++) begin
                    case ($urandom_range(0, 9))
                        0:       cmd = CMD_INIT;
                        1:       cmd = CMD_CLEAR;
                        2:       cmd = CMD_HOME;
                        default: cmd = CMD_WRITE;
                    endcase
                    push_command(cmd, 8'($urandom), 7'($urandom));
                    sent++;
                end
                sender_gap($urandom_range(0, 8));
            end
            wait_drained();
        end

        // then wait on, to catch any phase the block should not have made
        repeat (25) @(posedge i_clk);

        $display("sent %0d commands (init %0d, clear %0d, home %0d, write %0d)",
                 cmd_count[CMD_INIT] + cmd_count[CMD_CLEAR] + cmd_count[CMD_HOME] +
                 cmd_count[CMD_WRITE],
                 cmd_count[CMD_INIT], cmd_count[CMD_CLEAR], cmd_count[CMD_HOME],
                 cmd_count[CMD_WRITE]);
        $display("over %0d register settings; checked %0d bus phases, %0d reads, %0d failures",
                 setting_count, phase_count, read_count, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("char_lcd_bus_sequencer_tb passed");
        end else begin
            $display("char_lcd_bus_sequencer_tb failed");
        end
        $finish;
    end

endmodule

@@ char_lcd_bus_sequencer.f @@
+incdir+rtl
rtl/lcdseq_pkg.sv
rtl/lcdseq_cfg.sv
rtl/lcdseq_ucode.sv
rtl/lcdseq_dpath.sv
rtl/char_lcd_bus_sequencer.sv
rtl/lcdseq_checker.sv
dv/char_lcd_bus_sequencer_checker.sv
dv/char_lcd_bus_sequencer_tb.sv
